/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [4:0] CAP_RESET = 5'd16;

   localparam logic ACTION_ENQ = 1'b0;
   localparam logic ACTION_DEQ = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] new_prio;
      logic [7:0] new_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_prio;
      logic [7:0] out_char;
      logic [1:0] status;
      logic [4:0] count_after;
      logic       is_empty;
      logic       is_full;
   } rsp_type;

   typedef struct packed {
      logic [7:0] prio;
      logic [7:0] chr;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type entry;
   } cell_op_type;

endpackage

/* rtl/core/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell (
   input  logic                clock,
   input  spq_pkg::cell_op_type op,
   input  logic                occ,
   input  logic                left_gt,
   input  spq_pkg::entry_type  left_entry,
   input  spq_pkg::entry_type  right_entry,
   output spq_pkg::entry_type  entry,
   output logic                gt
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // an empty slot counts as greater, so insertion can land behind all held entries
   assign gt = !occ || (entry_ff.prio > op.entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (op.enq && gt) begin
         // first greater slot takes the new entry, the rest move back one
         entry_in = left_gt ? left_entry : op.entry;
      end else if (op.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps

// Sorted priority queue of (priority, character) entries held in a row of
// DEPTH cells, smallest priority at the head; equal priorities leave in
// arrival order. An enqueue (action 0) inserts the entry or is refused with
// status 1 when the count has reached the capacity register (values above
// DEPTH act as DEPTH). A dequeue (action 1) returns the head entry, or status
// 2 with zero fields when empty. Each request gives exactly one response, in
// the cycle after its transfer, with the count, empty and full after the
// operation. One operation is taken per clock: every cell moves its entry to
// a neighbor or takes the new one at the same edge, and a new request is
// taken at the same edge at which the previous response transfers; while a
// response is held by rsp_stall, req_stall is high. csr_wr_data (reset 16)
// should only change while no operation is outstanding.
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;

   logic [4:0]          cap_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   spq_pkg::rsp_type    rsp_data_ff;
   spq_pkg::rsp_type    rsp_data_in;

   logic                accept;
   logic                is_enq;
   logic                refuse;
   logic                do_enq;
   logic                do_deq;
   logic [CMPW-1:0]     cap_eff;
   logic [CMPW-1:0]     count_ext;
   logic [CMPW-1:0]     count_in_ext;
   logic [CW+4:0]       count_wide;
   spq_pkg::cell_op_type op;

   spq_pkg::entry_type  entries [DEPTH+1];
   logic [DEPTH-1:0]    gts;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_enq    = (req_data.action == spq_pkg::ACTION_ENQ);

   always_comb begin
      if (CMPW'(cap_ff) > CMPW'(DEPTH)) begin
         cap_eff = CMPW'(DEPTH);
      end else begin
         cap_eff = CMPW'(cap_ff);
      end
   end

   assign count_ext = CMPW'(count_ff);
   assign refuse    = (count_ext >= cap_eff);
   assign do_enq    = accept && is_enq && !refuse;
   assign do_deq    = accept && !is_enq && (count_ff != '0);

   assign op.enq   = do_enq;
   assign op.deq   = do_deq;
   assign op.entry = '{prio: req_data.new_prio, chr: req_data.new_char};

   assign entries[DEPTH] = '0;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         spq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occ         (count_ff > CW'(i)),
            .left_gt     ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
            .left_entry  (entries[(i == 0) ? 0 : i - 1]),
            .right_entry (entries[i + 1]),
            .entry       (entries[i]),
            .gt          (gts[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + CW'(1);
      end else if (do_deq) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_in_ext = CMPW'(count_in);
   assign count_wide   = (CW + 5)'(count_in);

   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.count_after = count_wide[4:0];
      rsp_data_in.is_empty    = (count_in == '0);
      rsp_data_in.is_full     = (count_in_ext >= cap_eff);
      if (is_enq) begin
         rsp_data_in.status = refuse ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_DONE;
      end else if (count_ff == '0) begin
         rsp_data_in.status = spq_pkg::STATUS_EMPTY;
      end else begin
         rsp_data_in.status   = spq_pkg::STATUS_DONE;
         rsp_data_in.out_prio = entries[0].prio;
         rsp_data_in.out_char = entries[0].chr;
      end
   end

   // hold a stalled response, drop it once transferred
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= spq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/spq_checker.sv */
`timescale 1ns / 1ps

module spq_port_assertions (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spq_pkg::rsp_type rsp_data
);

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed under stall");

   // every request transfer gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("request transfer without response");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.count_after == 5'd0)))
      else $error("empty flag disagrees with count");

   a_deq_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_EMPTY |->
         rsp_data.is_empty && rsp_data.out_prio == 8'd0 && rsp_data.out_char == 8'd0)
      else $error("dequeue on empty reports data");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == spq_pkg::STATUS_FULL |->
         rsp_data.is_full && rsp_data.out_prio == 8'd0)
      else $error("refused enqueue without full flag");

endmodule

bind sorted_priority_queue_top spq_port_assertions u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* dv/spq_checker.sv */
`timescale 1ns / 1ps

module spq_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  spq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  spq_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data,
   output int               failures,
   output int               pending
);
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;

   entry_type  held_q[$];
   rsp_type    expected_rsp_q[$];
   logic [4:0] capacity;
   rsp_type    want;
   int         fail_count = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Apply one operation to the mirrored queue and return the response it yields.
   function automatic rsp_type apply_queue_op(input req_type op);
      rsp_type   r;
      entry_type e;
      int        pos;
      int        eff_cap;
      eff_cap = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
      r = '0;
      if (op.action == ACTION_ENQ) begin
         if (held_q.size() >= eff_cap) begin
            r.status = STATUS_FULL;
         end else begin
            // insert behind every entry whose priority is not greater
            pos = held_q.size();
            while (pos > 0 && held_q[pos-1].prio > op.new_prio)
               pos--;
            e.prio = op.new_prio;
            e.chr  = op.new_char;
            held_q.insert(pos, e);
            r.status = STATUS_DONE;
         end
      end else begin
         if (held_q.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            e = held_q.pop_front();
            r.out_prio = e.prio;
            r.out_char = e.chr;
            r.status   = STATUS_DONE;
         end
      end
      r.count_after = 5'(held_q.size());
      r.is_empty    = (held_q.size() == 0);
      r.is_full     = (held_q.size() >= eff_cap);
      return r;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_q.delete();
         expected_rsp_q.delete();
         capacity = CAP_RESET;
      end else begin
         if (csr_wr_en)
            capacity = csr_wr_data;
         // a response never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response transfer with no operation outstanding");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("out_prio", want.out_prio, rsp_data.out_prio);
               check_field("out_char", want.out_char, rsp_data.out_char);
               check_field("status", want.status, rsp_data.status);
               check_field("count_after", want.count_after, rsp_data.count_after);
               check_field("is_empty", want.is_empty, rsp_data.is_empty);
               check_field("is_full", want.is_full, rsp_data.is_full);
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(apply_queue_op(req_data));
      end
      pending  <= expected_rsp_q.size();
      failures <= fail_count;
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_OPS   = 185;
   localparam int NUM_PHASES  = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   int failures;
   int pending;
   int holds_requested = 0;
   int holds_served    = 0;
   bit no_gaps         = 0;
   int ops_sent        = 0;
   int cap_writes      = 0;
   int idle_cycles     = 0;

   logic [4:0] phase_cap[NUM_PHASES] = '{5'd31, 5'd16, 5'd1, 5'd5, 5'd16,
                                         5'd0, 5'd3, 5'd31, 5'd9, 5'd16};
   int         phase_enq[NUM_PHASES] = '{70, 60, 55, 50, 70, 50, 60, 45, 60, 40};

   sorted_priority_queue_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   spq_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stalls, clean stretches, and long hold-offs on request.
   initial begin
      int r;
      rsp_stall <= 1'b0;
      forever begin
         if (holds_served < holds_requested) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end else if (r < 27) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(8, 30)) @(posedge clock);
            end else begin
               rsp_stall <= ($urandom_range(0, 99) < 30);
               @(posedge clock);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one operation, hold it until the transfer, then maybe go idle.
   task automatic send_op(input logic act, input logic [7:0] prio, input logic [7:0] chr);
      req_type op;
      int      gap;
      op.action   = act;
      op.new_prio = prio;
      op.new_char = chr;
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (req_stall);
      ops_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_writes++;
   endtask

   task automatic run_phase(input logic [4:0] cap, input int enq_pct);
      logic       act;
      logic [7:0] prio;
      int         r;
      write_capacity(cap);
      repeat (PHASE_OPS) begin
         act = ($urandom_range(0, 99) < enq_pct) ? ACTION_ENQ : ACTION_DEQ;
         r = $urandom_range(0, 9);
         // coarse priorities make plenty of ties, including at both extremes
         if (r < 4)
            prio = 8'($urandom_range(0, 3) * 85);
         else if (r == 4)
            prio = 8'($urandom_range(250, 255));
         else
            prio = 8'($urandom_range(0, 255));
         send_op(act, prio, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CAP_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, extremes and ties at the reset capacity
      send_op(ACTION_DEQ, 8'd0, 8'd0);
      send_op(ACTION_ENQ, 8'd255, 8'h00);
      send_op(ACTION_ENQ, 8'd0, 8'hFF);
      send_op(ACTION_ENQ, 8'd128, 8'hAA);
      send_op(ACTION_ENQ, 8'd128, 8'h55);
      send_op(ACTION_ENQ, 8'd0, 8'h01);
      send_op(ACTION_ENQ, 8'd255, 8'hFF);
      repeat (6) send_op(ACTION_DEQ, 8'hFF, 8'hFF);
      send_op(ACTION_DEQ, 8'd0, 8'd0);

      // lower the capacity below the held count, then drain
      send_op(ACTION_ENQ, 8'd10, 8'h31);
      send_op(ACTION_ENQ, 8'd5, 8'h32);
      send_op(ACTION_ENQ, 8'd10, 8'h33);
      write_capacity(5'd2);
      send_op(ACTION_ENQ, 8'd1, 8'h34);
      send_op(ACTION_DEQ, 8'd0, 8'd0);
      send_op(ACTION_ENQ, 8'd1, 8'h35);
      send_op(ACTION_DEQ, 8'd0, 8'd0);
      send_op(ACTION_DEQ, 8'd0, 8'd0);
      send_op(ACTION_DEQ, 8'd0, 8'd0);

      // zero capacity refuses every enqueue
      write_capacity(5'd0);
      send_op(ACTION_ENQ, 8'd7, 8'h36);
      send_op(ACTION_DEQ, 8'd0, 8'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 4) begin
            no_gaps = 1'b1;
            holds_requested++;
         end
         run_phase(phase_cap[p], phase_enq[p]);
         no_gaps = 1'b0;
      end

      settle();
      repeat (5) @(posedge clock);
      $display("Ran %0d queue operations over %0d capacity settings (0 to 31),",
               ops_sent, cap_writes);
      $display("with random stalls on both sides and %0d long response hold-off(s).",
               holds_served);
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
